>>> design/ccfd_pkg.sv
`timescale 1ns / 1ps

package ccfd_pkg;

	localparam int FRAME_CAP_DEF = 256;
	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd254;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] CODE_FULL_BLOCK = 8'hFF;
	localparam logic [7:0] DELIMITER = 8'h00;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_OVER_CAP  = 3'd2;
	localparam logic [2:0] ST_TOO_SHORT = 3'd3;
	localparam logic [2:0] ST_CRC_BAD   = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       frame_end;
		logic [2:0] frame_status;
		logic [7:0] payload_length;
	} res_t;

	// MSB-first CRC-16/CCITT-FALSE update by one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> design/cobs_crc_frame_decoder.sv
`timescale 1ns / 1ps

// A result is decoded combinationally and queued when the byte causing it is taken.
// Throughput: one wire byte per cycle while the result queue is not full.
// A two-entry result queue lets input keep flowing while the sink stalls one result.
// Reset (arst_n low, asynchronous): frame state cleared, CRC at 0xFFFF, queue empty,
// max_payload back to 254.
module cobs_crc_frame_decoder #(
	parameter int FRAME_CAP = ccfd_pkg::FRAME_CAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] wire_byte,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       byte_valid,
	output logic       frame_end,
	output logic [2:0] frame_status,
	output logic [7:0] payload_length
);

	logic [7:0]     max_payload_q;
	logic           take;
	logic           res_valid;
	logic           full;
	ccfd_pkg::res_t res;
	ccfd_pkg::res_t out_data;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= ccfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	ccfd_decode #(
		.FRAME_CAP (FRAME_CAP)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.wire_byte   (wire_byte),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	ccfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign payload_byte   = out_data.payload_byte;
	assign byte_valid     = out_data.byte_valid;
	assign frame_end      = out_data.frame_end;
	assign frame_status   = out_data.frame_status;
	assign payload_length = out_data.payload_length;

endmodule

>>> design/ccfd_decode.sv
`timescale 1ns / 1ps

module ccfd_decode #(
	parameter int FRAME_CAP = ccfd_pkg::FRAME_CAP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           wire_byte,
	input  logic [7:0]           max_payload,
	output logic                 res_valid,
	output ccfd_pkg::res_t       res
);

	localparam int CW = $clog2(FRAME_CAP + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	logic [7:0]    block_remaining_q, block_remaining_d;
	logic          zero_pending_q, zero_pending_d;
	logic [7:0]    tail0_q, tail0_d, tail1_q, tail1_d;
	logic [1:0]    tail_fill_q, tail_fill_d;
	logic [15:0]   crc_q, crc_d;
	logic [CW-1:0] count_q, count_d;
	logic [2:0]    err_q, err_d;

	logic          push;
	logic [7:0]    push_byte;
	logic [PW-1:0] plen_w;

	always_comb begin
		block_remaining_d = block_remaining_q;
		zero_pending_d    = zero_pending_q;
		tail0_d           = tail0_q;
		tail1_d           = tail1_q;
		tail_fill_d       = tail_fill_q;
		crc_d             = crc_q;
		count_d           = count_q;
		err_d             = err_q;
		push              = 1'b0;
		push_byte         = wire_byte;
		res_valid         = 1'b0;
		res               = '0;
		plen_w            = PW'(count_q) - PW'(2);

		if (wire_byte == ccfd_pkg::DELIMITER) begin
			res_valid     = 1'b1;
			res.frame_end = 1'b1;
			if (block_remaining_q != 8'd0) begin
				res.frame_status = ccfd_pkg::ST_TRUNCATED;
			end else if (err_q != ccfd_pkg::ST_OK) begin
				res.frame_status = err_q;
			end else if (count_q < CW'(2)) begin
				res.frame_status = ccfd_pkg::ST_TOO_SHORT;
			end else begin
				res.payload_length = (plen_w > PW'(255)) ? 8'hFF : plen_w[7:0];
				if ({tail0_q, tail1_q} != crc_q) begin
					res.frame_status = ccfd_pkg::ST_CRC_BAD;
				end else if (plen_w > PW'(max_payload)) begin
					res.frame_status = ccfd_pkg::ST_TOO_LONG;
				end else begin
					res.frame_status = ccfd_pkg::ST_OK;
				end
			end
			block_remaining_d = 8'd0;
			zero_pending_d    = 1'b0;
			tail0_d           = 8'd0;
			tail1_d           = 8'd0;
			tail_fill_d       = 2'd0;
			crc_d             = ccfd_pkg::CRC_INIT;
			count_d           = '0;
			err_d             = ccfd_pkg::ST_OK;
		end else begin
			if (block_remaining_q == 8'd0) begin
				// code byte: flush the zero implied by the previous short block
				push              = zero_pending_q;
				push_byte         = 8'd0;
				block_remaining_d = wire_byte - 8'd1;
				zero_pending_d    = (wire_byte != ccfd_pkg::CODE_FULL_BLOCK);
			end else begin
				push              = 1'b1;
				block_remaining_d = block_remaining_q - 8'd1;
			end

			if (push && err_q == ccfd_pkg::ST_OK) begin
				if (count_q >= CW'(FRAME_CAP)) begin
					err_d = ccfd_pkg::ST_OVER_CAP;
				end else begin
					count_d = count_q + CW'(1);
					if (tail_fill_q == 2'd0) begin
						tail0_d     = push_byte;
						tail_fill_d = 2'd1;
					end else if (tail_fill_q == 2'd1) begin
						tail1_d     = push_byte;
						tail_fill_d = 2'd2;
					end else begin
						// oldest byte leaves the CRC-trailer window
						res_valid        = 1'b1;
						res.payload_byte = tail0_q;
						res.byte_valid   = 1'b1;
						crc_d            = ccfd_pkg::crc_byte(crc_q, tail0_q);
						tail0_d          = tail1_q;
						tail1_d          = push_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_remaining_q <= 8'd0;
			zero_pending_q    <= 1'b0;
			tail0_q           <= 8'd0;
			tail1_q           <= 8'd0;
			tail_fill_q       <= 2'd0;
			crc_q             <= ccfd_pkg::CRC_INIT;
			count_q           <= '0;
			err_q             <= ccfd_pkg::ST_OK;
		end else if (take) begin
			block_remaining_q <= block_remaining_d;
			zero_pending_q    <= zero_pending_d;
			tail0_q           <= tail0_d;
			tail1_q           <= tail1_d;
			tail_fill_q       <= tail_fill_d;
			crc_q             <= crc_d;
			count_q           <= count_d;
			err_q             <= err_d;
		end
	end

endmodule

>>> design/ccfd_out_buf.sv
`timescale 1ns / 1ps

module ccfd_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ccfd_pkg::res_t push_data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output ccfd_pkg::res_t out_data
);

	ccfd_pkg::res_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_OFF = 3;
	localparam int TAIL_CYCLES = 8;
	localparam int STUCK_LIMIT = 2000;
	// total wire bytes, directed part included
	localparam int WIRE_BYTES = 1500;

	typedef enum logic [1:0] {FEED_BYTE, SET_MAX, WAIT_IDLE} feed_kind_t;
	typedef enum logic [1:0] {FR_GOOD, FR_BAD_CRC, FR_CUT, FR_NOISE} frame_mode_t;

	typedef struct {
		feed_kind_t kind;
		logic [7:0] value;
	} feed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] wire_byte = 8'h00;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic       frame_end;
	logic [2:0] frame_status;
	logic [7:0] payload_length;

	cobs_crc_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.wire_byte(wire_byte),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.frame_end(frame_end),
		.frame_status(frame_status),
		.payload_length(payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	// ---------------- deframer prediction ----------------
	feed_t           wire_q[$];
	ccfd_pkg::res_t  deframed_q[$];
	logic [7:0]      raw_q[$];
	int              wire_count = 0;

	logic [7:0] len_limit = ccfd_pkg::MAX_PAYLOAD_RST;
	logic [7:0] blk_left = 8'd0;
	logic       zero_due = 1'b0;
	logic [7:0] tail[2] = '{8'h00, 8'h00};
	logic [1:0] tail_cnt = 2'd0;
	logic [15:0] crc_acc = ccfd_pkg::CRC_INIT;
	int         dec_cnt = 0;
	logic [2:0] frm_err = ccfd_pkg::ST_OK;

	// bit-serial form, MSB first
	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? ccfd_pkg::CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic string res_str(input ccfd_pkg::res_t r);
		return $sformatf("byte=%h bv=%b end=%b st=%0d len=%0d", r.payload_byte,
			r.byte_valid, r.frame_end, r.frame_status, r.payload_length);
	endfunction

	function automatic void clear_frame();
		blk_left = 8'd0;
		zero_due = 1'b0;
		tail[0] = 8'h00;
		tail[1] = 8'h00;
		tail_cnt = 2'd0;
		crc_acc = ccfd_pkg::CRC_INIT;
		dec_cnt = 0;
		frm_err = ccfd_pkg::ST_OK;
	endfunction

	// decoded byte enters the two-byte delay; the byte pushed out is payload
	function automatic void take_decoded(input logic [7:0] b);
		ccfd_pkg::res_t r;
		if (frm_err != ccfd_pkg::ST_OK)
			return;
		if (dec_cnt >= ccfd_pkg::FRAME_CAP_DEF) begin
			frm_err = ccfd_pkg::ST_OVER_CAP;
			return;
		end
		dec_cnt++;
		if (tail_cnt < 2) begin
			tail[tail_cnt] = b;
			tail_cnt++;
			return;
		end
		r = '0;
		r.payload_byte = tail[0];
		r.byte_valid = 1'b1;
		crc_acc = crc16_next(crc_acc, tail[0]);
		tail[0] = tail[1];
		tail[1] = b;
		deframed_q.push_back(r);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		ccfd_pkg::res_t r;
		logic [2:0] st;
		int plen;
		if (b == ccfd_pkg::DELIMITER) begin
			plen = 0;
			if (blk_left != 0) begin
				st = ccfd_pkg::ST_TRUNCATED;
			end else if (frm_err != ccfd_pkg::ST_OK) begin
				st = frm_err;
			end else if (dec_cnt < 2) begin
				st = ccfd_pkg::ST_TOO_SHORT;
			end else begin
				plen = dec_cnt - 2;
				if ({tail[0], tail[1]} != crc_acc)
					st = ccfd_pkg::ST_CRC_BAD;
				else if (plen > len_limit)
					st = ccfd_pkg::ST_TOO_LONG;
				else
					st = ccfd_pkg::ST_OK;
			end
			if (plen > 255)
				plen = 255;
			r = '0;
			r.frame_end = 1'b1;
			r.frame_status = st;
			r.payload_length = plen[7:0];
			deframed_q.push_back(r);
			clear_frame();
		end else if (blk_left == 0) begin
			// code byte: the zero owed by the previous block comes first
			if (zero_due)
				take_decoded(8'h00);
			blk_left = b - 8'd1;
			zero_due = (b != ccfd_pkg::CODE_FULL_BLOCK);
		end else begin
			take_decoded(b);
			blk_left--;
		end
	endfunction

	// ---------------- stimulus ----------------
	function automatic void push_wire(input logic [7:0] b);
		feed_t f;
		f.kind = FEED_BYTE;
		f.value = b;
		wire_q.push_back(f);
		wire_count++;
	endfunction

	function automatic void push_ctrl(input feed_kind_t k, input logic [7:0] v);
		feed_t f;
		f.kind = k;
		f.value = v;
		wire_q.push_back(f);
	endfunction

	// COBS-encode raw_q and close the frame
	function automatic void cobs_out();
		logic [7:0] blk[$];
		int n;
		n = raw_q.size();
		for (int i = 0; i <= n; i++) begin
			if (i < n && raw_q[i] != 8'h00)
				blk.push_back(raw_q[i]);
			if (i == n || raw_q[i] == 8'h00 || blk.size() == 254) begin
				push_wire(8'(blk.size() + 1));
				foreach (blk[j])
					push_wire(blk[j]);
				blk.delete();
			end
		end
		push_wire(ccfd_pkg::DELIMITER);
	endfunction

	function automatic void send_frame(input int n, input frame_mode_t mode, input int zero_pct);
		logic [15:0] c;
		logic [7:0] b;
		int k;
		if (mode == FR_NOISE) begin
			for (int i = 0; i < n; i++)
				push_wire(8'($urandom_range(0, 255)));
			push_wire(ccfd_pkg::DELIMITER);
			return;
		end
		raw_q.delete();
		c = ccfd_pkg::CRC_INIT;
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
			raw_q.push_back(b);
			c = crc16_next(c, b);
		end
		raw_q.push_back(c[15:8]);
		raw_q.push_back(c[7:0]);
		if (mode == FR_BAD_CRC) begin
			k = $urandom_range(0, raw_q.size() - 1);
			raw_q[k] = raw_q[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		cobs_out();
		// drop one or two bytes just ahead of the delimiter
		if (mode == FR_CUT) begin
			k = $urandom_range(1, 2);
			repeat (k) begin
				wire_q.delete(wire_q.size() - 2);
				wire_count--;
			end
		end
	endfunction

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(0, 3))
			0: pick_limit = 8'd0;
			1: pick_limit = 8'd254;
			2: pick_limit = 8'($urandom_range(0, 254));
			default: pick_limit = 8'($urandom_range(0, 16));
		endcase
	endfunction

	initial begin
		int frames;
		int sz;
		int r;
		int zp;
		frame_mode_t mode;

		// directed: delimiter corner cases, both code extremes, statuses
		push_ctrl(SET_MAX, 8'd254);
		push_wire(8'h00);
		push_wire(8'h02); push_wire(8'hAA); push_wire(8'h00);
		push_wire(8'h03); push_wire(8'h11); push_wire(8'h00);
		push_wire(8'hFF); push_wire(8'h00);
		push_wire(8'h01); push_wire(8'h01); push_wire(8'h00);
		push_wire(8'h03); push_wire(8'h12); push_wire(8'h34); push_wire(8'h00);
		send_frame(0, FR_GOOD, 0);
		push_ctrl(SET_MAX, 8'd0);
		send_frame(1, FR_GOOD, 100);
		push_ctrl(SET_MAX, 8'd1);
		send_frame(1, FR_GOOD, 0);

		// full capacity with 0xFF blocks, then one byte past capacity
		push_ctrl(SET_MAX, 8'd254);
		send_frame(254, FR_GOOD, 0);
		send_frame(255, FR_GOOD, 0);
		push_ctrl(WAIT_IDLE, 8'h00);

		frames = 0;
		while (wire_count < WIRE_BYTES) begin
			frames++;
			if (frames % 25 == 0)
				push_ctrl(SET_MAX, pick_limit());
			if (frames == 40)
				push_ctrl(WAIT_IDLE, 8'h00);
			r = $urandom_range(0, 99);
			if (r < 90)
				sz = $urandom_range(0, 16);
			else if (r < 97)
				sz = $urandom_range(17, 60);
			else
				sz = $urandom_range(200, 300);
			r = $urandom_range(0, 99);
			if (r < 70)
				mode = FR_GOOD;
			else if (r < 82)
				mode = FR_BAD_CRC;
			else if (r < 92)
				mode = FR_CUT;
			else
				mode = FR_NOISE;
			case ($urandom_range(0, 3))
				0: zp = 0;
				1: zp = 10;
				2: zp = 50;
				default: zp = 100;
			endcase
			send_frame(sz, mode, zp);
		end
	end

	// ---------------- idle pattern ----------------
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 59) == 0)
			calm = $urandom_range(20, 120);
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// ---------------- driver ----------------
	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic feed_done = 1'b0;
	int   src_gap = 0;
	int   src_calm = 0;
	int   quiet_wait = HOLD_OFF;

	always @(negedge clk) begin
		logic       v_next;
		logic [7:0] b_next;
		logic       we_next;
		logic [7:0] d_next;
		logic       done_next;
		v_next = in_valid;
		b_next = wire_byte;
		we_next = 1'b0;
		d_next = cfg_wdata;
		done_next = 1'b0;
		if (arst_n && (!in_valid || in_took)) begin
			v_next = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (wire_q.size() != 0) begin
				if (wire_q[0].kind == FEED_BYTE) begin
					v_next = 1'b1;
					b_next = wire_q[0].value;
					void'(wire_q.pop_front());
					src_gap = idle_len(src_calm);
					quiet_wait = HOLD_OFF;
				end else if (deframed_q.size() != 0) begin
					quiet_wait = HOLD_OFF;
				end else if (quiet_wait > 0) begin
					quiet_wait--;
				end else begin
					// block drained and settled: register write or just resume
					if (wire_q[0].kind == SET_MAX) begin
						we_next = 1'b1;
						d_next = wire_q[0].value;
					end
					void'(wire_q.pop_front());
					quiet_wait = HOLD_OFF;
				end
			end
			done_next = !v_next && wire_q.size() == 0;
		end
		in_valid <= v_next;
		wire_byte <= b_next;
		cfg_we <= we_next;
		cfg_wdata <= d_next;
		feed_done <= done_next;
	end

	// result sink backpressure
	int sink_stall = 0;
	int sink_calm = 0;

	always @(negedge clk) begin
		int s;
		s = sink_stall;
		if (arst_n && out_took)
			s = idle_len(sink_calm);
		if (s > 0) begin
			out_ready <= 1'b0;
			s--;
		end else begin
			out_ready <= arst_n;
		end
		sink_stall = s;
	end

	// ---------------- monitor / checker ----------------
	int mismatches = 0;
	int stuck_cycles = 0;
	int settle = 0;

	always @(posedge clk) begin
		ccfd_pkg::res_t seen;
		ccfd_pkg::res_t want;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			out_took <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				seen.payload_byte = payload_byte;
				seen.byte_valid = byte_valid;
				seen.frame_end = frame_end;
				seen.frame_status = frame_status;
				seen.payload_length = payload_length;
				if (deframed_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got %s",
						$time, res_str(seen));
				end else begin
					want = deframed_q.pop_front();
					if (seen !== want) begin
						mismatches++;
						$display("%0t: mismatch, expected %s, got %s",
							$time, res_str(want), res_str(seen));
					end
				end
			end
			if (cfg_we)
				len_limit = cfg_wdata;
			if (in_valid && in_ready)
				deframe_byte(wire_byte);

			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (feed_done && deframed_q.size() == 0)
				settle++;
			else
				settle = 0;

			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, stuck_cycles, deframed_q.size());
				$display("cobs_crc_frame_decoder regression: fail");
				$finish;
			end else if (settle >= TAIL_CYCLES) begin
				if (mismatches == 0) begin
					$display("cobs_crc_frame_decoder regression: pass");
				end else begin
					$display("cobs_crc_frame_decoder regression: fail");
				end
				$finish;
			end
		end
	end

endmodule
